### rtl/rrhm_pkg.sv
// Shared types and constants for the round-robin handle map.
`timescale 1ns / 1ps

package rrhm_pkg;

	localparam int MODE_W = 3;
	localparam int KEY_W  = 32;
	localparam int ID_W   = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_MAP      = 3'd0,
		MODE_ATTACH   = 3'd1,
		MODE_FREE_ID  = 3'd2,
		MODE_FREE_KEY = 3'd3,
		MODE_FIND     = 3'd4,
		MODE_READ     = 3'd5
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic scan_clr;
		logic scan_run;
		logic alloc_init;
		logic alloc_next;
		logic slot_rd;
		logic res_fail;
		logic res_hit;
		logic res_slot;
		logic res_alloc;
		logic free_hit;
		logic free_slot;
		logic attach;
		logic load_out;
	} rrhm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              key_zero;
		logic              hit;
		logic              scan_end;
		logic              slot_ok;
		logic              alloc_free;
		logic              alloc_wrap;
	} rrhm_stat_t;

endpackage

### rtl/rrhm_req_if.sv
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps

interface rrhm_req_if
	import rrhm_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  chan_key;
	logic [ID_W-1:0]   slot_id;
	logic [KEY_W-1:0]  media_key;

	modport source (output valid, output mode, output chan_key, output slot_id,
		output media_key, input ready);
	modport sink (input valid, input mode, input chan_key, input slot_id,
		input media_key, output ready);
endinterface

### rtl/rrhm_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface rrhm_rsp_if
	import rrhm_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             ok;
	logic [ID_W-1:0]  result_id;
	logic [KEY_W-1:0] result_key;
	logic [KEY_W-1:0] result_media;

	modport source (output valid, output ok, output result_id, output result_key,
		output result_media, input ready);
	modport sink (input valid, input ok, input result_id, input result_key,
		input result_media, output ready);
endinterface

### rtl/rrhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/rrhm_ctrl.sv
// Controller state machine: sequences search, allocation and slot operations.
`timescale 1ns / 1ps

module rrhm_ctrl
	import rrhm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  rrhm_stat_t st,
	output rrhm_cmd_t  cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEARCH,
		ST_ALLOC,
		ST_SLOT_RD,
		ST_SLOT_ACT,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_vld_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (st.mode)
					MODE_MAP, MODE_FIND: begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SEARCH;
					end
					MODE_FREE_KEY: begin
						if (st.key_zero) begin
							cmd.res_fail = 1'b1;
							state_d      = ST_FINISH;
						end else begin
							cmd.scan_clr = 1'b1;
							state_d      = ST_SEARCH;
						end
					end
					MODE_ATTACH, MODE_FREE_ID, MODE_READ: begin
						state_d = ST_SLOT_RD;
					end
					default: begin
						cmd.res_fail = 1'b1;
						state_d      = ST_FINISH;
					end
				endcase
			end
			ST_SEARCH: begin
				cmd.scan_run = 1'b1;
				if (st.hit) begin
					cmd.res_hit  = 1'b1;
					cmd.free_hit = (st.mode == MODE_FREE_KEY);
					state_d      = ST_FINISH;
				end else if (st.scan_end) begin
					if (st.mode == MODE_MAP) begin
						cmd.alloc_init = 1'b1;
						state_d        = ST_ALLOC;
					end else begin
						cmd.res_fail = 1'b1;
						state_d      = ST_FINISH;
					end
				end
			end
			ST_ALLOC: begin
				priority if (st.alloc_wrap) begin
					cmd.res_fail = 1'b1;
					state_d      = ST_FINISH;
				end else if (st.alloc_free) begin
					cmd.res_alloc = 1'b1;
					state_d       = ST_FINISH;
				end else begin
					cmd.alloc_next = 1'b1;
				end
			end
			ST_SLOT_RD: begin
				cmd.slot_rd = 1'b1;
				state_d     = ST_SLOT_ACT;
			end
			ST_SLOT_ACT: begin
				if (st.slot_ok) begin
					cmd.res_slot  = 1'b1;
					cmd.attach    = (st.mode == MODE_ATTACH);
					cmd.free_slot = (st.mode == MODE_FREE_ID);
				end else begin
					cmd.res_fail = 1'b1;
				end
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_vld_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/rrhm_dp.sv
// Datapath: request registers, key and media RAMs, occupancy bits, scan counters, result.
`timescale 1ns / 1ps

module rrhm_dp
	import rrhm_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rrhm_cmd_t         cmd,
	output rrhm_stat_t        st,
	input  logic [MODE_W-1:0] in_mode,
	input  logic [KEY_W-1:0]  in_chan_key,
	input  logic [ID_W-1:0]   in_slot_id,
	input  logic [KEY_W-1:0]  in_media_key,
	output logic              out_ok,
	output logic [ID_W-1:0]   out_result_id,
	output logic [KEY_W-1:0]  out_result_key,
	output logic [KEY_W-1:0]  out_result_media
);
	localparam int               IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST  = IDX_W'(SLOTS - 1);

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	// Request registers
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [ID_W-1:0]   sid_q;
	logic [KEY_W-1:0]  media_q;

	// Table state
	logic [SLOTS-1:0]  occ_q;
	logic [IDX_W-1:0]  last_alloc_q;

	// Scan and allocation walk
	logic [IDX_W-1:0]  scan_idx_q;
	logic              issue_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [IDX_W-1:0]  alloc_idx_q;

	// Work result and output register
	logic              res_ok_q;
	logic [IDX_W-1:0]  res_id_q;
	logic [KEY_W-1:0]  res_key_q;
	logic [KEY_W-1:0]  res_media_q;
	logic              out_ok_q;
	logic [ID_W-1:0]   out_id_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [KEY_W-1:0]  out_media_q;

	logic [IDX_W-1:0]  sid_idx;
	logic              in_range;
	logic [IDX_W-1:0]  raddr;
	logic [KEY_W-1:0]  key_rd;
	logic [KEY_W-1:0]  media_rd;
	logic              media_we;
	logic [IDX_W-1:0]  media_waddr;
	logic [KEY_W-1:0]  media_wdata;
	logic              match;

	assign sid_idx  = sid_q[IDX_W-1:0];
	assign in_range = ({1'b0, sid_q} < (ID_W + 1)'(SLOTS));
	assign raddr    = cmd.slot_rd ? sid_idx : scan_idx_q;

	assign media_we    = cmd.res_alloc | cmd.attach;
	assign media_waddr = cmd.attach ? sid_idx : alloc_idx_q;
	assign media_wdata = cmd.attach ? media_q : '0;

	rrhm_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (cmd.res_alloc),
		.waddr (alloc_idx_q),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (key_rd)
	);

	rrhm_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_media_ram (
		.clk   (clk),
		.we    (media_we),
		.waddr (media_waddr),
		.wdata (media_wdata),
		.raddr (raddr),
		.rdata (media_rd)
	);

	// A zero key matches the first free slot; others match an occupied slot.
	assign match = (key_q == '0) ? !occ_q[cmp_idx_s1]
		: (occ_q[cmp_idx_s1] && (key_rd == key_q));

	always_comb begin
		st            = '0;
		st.mode       = mode_q;
		st.key_zero   = (key_q == '0);
		st.hit        = cmp_vld_s1 && match;
		st.scan_end   = cmp_vld_s1 && (cmp_idx_s1 == LAST);
		st.slot_ok    = in_range && occ_q[sid_idx];
		st.alloc_free = !occ_q[alloc_idx_q];
		st.alloc_wrap = (alloc_idx_q == last_alloc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			last_alloc_q <= '0;
			issue_q      <= 1'b0;
			cmp_vld_s1   <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				issue_q    <= 1'b1;
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				cmp_vld_s1 <= issue_q;
				if (issue_q && (scan_idx_q == LAST)) begin
					issue_q <= 1'b0;
				end
			end
			if (cmd.res_alloc) begin
				occ_q[alloc_idx_q] <= 1'b1;
				last_alloc_q       <= alloc_idx_q;
			end
			if (cmd.free_hit) begin
				occ_q[cmp_idx_s1] <= 1'b0;
			end
			if (cmd.free_slot) begin
				occ_q[sid_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= in_mode;
			key_q   <= in_chan_key;
			sid_q   <= in_slot_id;
			media_q <= in_media_key;
		end
		if (cmd.scan_clr) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_run && issue_q) begin
			cmp_idx_s1 <= scan_idx_q;
			if (scan_idx_q != LAST) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
		if (cmd.alloc_init) begin
			alloc_idx_q <= wrap_inc(last_alloc_q);
		end else if (cmd.alloc_next) begin
			alloc_idx_q <= wrap_inc(alloc_idx_q);
		end
		priority if (cmd.res_fail) begin
			res_ok_q    <= 1'b0;
			res_id_q    <= '0;
			res_key_q   <= '0;
			res_media_q <= '0;
		end else if (cmd.res_hit) begin
			res_ok_q    <= 1'b1;
			res_id_q    <= cmp_idx_s1;
			res_key_q   <= '0;
			res_media_q <= '0;
		end else if (cmd.res_alloc) begin
			res_ok_q    <= 1'b1;
			res_id_q    <= alloc_idx_q;
			res_key_q   <= '0;
			res_media_q <= '0;
		end else if (cmd.res_slot) begin
			res_ok_q    <= 1'b1;
			res_id_q    <= sid_idx;
			res_key_q   <= (mode_q == MODE_READ) ? key_rd : '0;
			res_media_q <= (mode_q == MODE_READ) ? media_rd : '0;
		end
		if (cmd.load_out) begin
			out_ok_q    <= res_ok_q;
			out_id_q    <= ID_W'(res_id_q);
			out_key_q   <= res_key_q;
			out_media_q <= res_media_q;
		end
	end

	assign out_ok           = out_ok_q;
	assign out_result_id    = out_id_q;
	assign out_result_key   = out_key_q;
	assign out_result_media = out_media_q;
endmodule

### rtl/round_robin_handle_map.sv
// Top level of the round-robin handle map: controller, datapath and channel hookup.
`timescale 1ns / 1ps

// The round-robin handle map binds nonzero 32-bit channel keys to slot ids
// 0..SLOTS-1 and keeps a 32-bit media value per slot. Each request beat gives
// exactly one response beat. Keys and media sit in two single-port-read RAMs;
// a flip-flop occupancy bit per slot marks which slots are in use, so reset
// takes effect at once with no clearing pass. Requests are handled one at a
// time. Key searches (map, find, free by key) read the key RAM one slot per
// cycle and stop at the first match. A map that misses then walks the
// occupancy bits one slot per cycle, starting one past the last allocated id.
// A finished response waits in an output register, so the next request beat
// is taken while the previous response is still pending.

module round_robin_handle_map
	import rrhm_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input logic        clk,
	input logic        arst_n,
	rrhm_req_if.sink   req,
	rrhm_rsp_if.source rsp
);
	rrhm_cmd_t  cmd;
	rrhm_stat_t st;
	logic       req_ready;
	logic       rsp_valid;

	// Sequence each request: decode, scan or slot access, then hand off the result.
	rrhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Hold the tables and the result; the response payload comes from here.
	rrhm_dp #(.SLOTS(SLOTS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_mode          (req.mode),
		.in_chan_key      (req.chan_key),
		.in_slot_id       (req.slot_id),
		.in_media_key     (req.media_key),
		.out_ok           (rsp.ok),
		.out_result_id    (rsp.result_id),
		.out_result_key   (rsp.result_key),
		.out_result_media (rsp.result_media)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
endmodule

### sim/tb.sv
// Self-checking testbench for round_robin_handle_map against a predictor.
`timescale 1ns / 1ps

module tb;
	import rrhm_pkg::*;

	localparam int SLOTS        = 64;
	localparam int IDLE_PCT     = 6;
	localparam int RANDOM_ITEMS = 1050;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_CAP   = 40;
	localparam int POOL_N       = 24;
	localparam int CALM_FIRST   = 450;
	localparam int CALM_LAST    = 700;

	// Mode codes the block must reject.
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	// Random phase styles.
	localparam int STYLE_FILL  = 0;
	localparam int STYLE_CHURN = 1;
	localparam int STYLE_DRAIN = 2;

	typedef struct packed {
		logic              drain_first;	// hold this beat until all responses are back
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  chan_key;
		logic [ID_W-1:0]   slot_id;
		logic [KEY_W-1:0]  media_key;
	} request_t;

	typedef struct packed {
		logic             ok;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] media;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	rrhm_req_if req_ch ();
	rrhm_rsp_if rsp_ch ();

	round_robin_handle_map #(
		.SLOTS(SLOTS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #6 clk = ~clk;

	// Shadow of the handle table, kept in step with every accepted request.
	logic [KEY_W-1:0] slot_key   [SLOTS];
	logic [KEY_W-1:0] slot_media [SLOTS];
	int unsigned      last_alloc;

	request_t queued_requests [$];	// stimulus not yet presented
	outcome_t due_results [$];	// predicted responses, oldest first
	logic [KEY_W-1:0] key_pool [POOL_N];	// recurring keys so searches hit

	int    total_items;
	int    beats_taken;
	int    failures;
	int    cycle_count;
	logic  req_beat;
	logic  calm;
	request_t head_req;
	request_t taken_req;
	outcome_t want;
	outcome_t got;

	// Lowest slot holding key k, or -1. A zero key matches the lowest free slot.
	function automatic int slot_of_key(logic [KEY_W-1:0] k);
		int hit;
		hit = -1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (slot_key[i] == k) hit = i;
		return hit;
	endfunction

	// Apply one request to the shadow table and return the response it must produce.
	function automatic outcome_t apply_request(request_t r);
		outcome_t    o;
		int          hit;
		int unsigned start;
		int unsigned idx;
		logic        live;
		o = '0;
		live = 1'b0;
		if (r.slot_id < SLOTS)
			live = slot_key[r.slot_id] != '0;
		case (r.mode)
			MODE_MAP: begin
				hit = slot_of_key(r.chan_key);
				if (hit >= 0) begin
					o.ok = 1'b1;
					o.id = hit[ID_W-1:0];
				end else begin
					// Walk forward from one past the last allocation; that slot is never retried.
					start = last_alloc;
					for (int n = 1; n < SLOTS; n++) begin
						idx = (start + n) % SLOTS;
						if (!o.ok && slot_key[idx] == '0) begin
							slot_key[idx]   = r.chan_key;
							slot_media[idx] = '0;
							last_alloc      = idx;
							o.ok = 1'b1;
							o.id = idx[ID_W-1:0];
						end
					end
				end
			end
			MODE_ATTACH: begin
				if (live) begin
					slot_media[r.slot_id] = r.media_key;
					o.ok = 1'b1;
					o.id = r.slot_id;
				end
			end
			MODE_FREE_ID: begin
				if (live) begin
					slot_key[r.slot_id]   = '0;
					slot_media[r.slot_id] = '0;
					o.ok = 1'b1;
					o.id = r.slot_id;
				end
			end
			MODE_FREE_KEY: begin
				// A zero key would match a free slot; freeing it is refused outright.
				if (r.chan_key != '0) begin
					hit = slot_of_key(r.chan_key);
					if (hit >= 0) begin
						slot_key[hit]   = '0;
						slot_media[hit] = '0;
						o.ok = 1'b1;
						o.id = hit[ID_W-1:0];
					end
				end
			end
			MODE_FIND: begin
				hit = slot_of_key(r.chan_key);
				if (hit >= 0) begin
					o.ok = 1'b1;
					o.id = hit[ID_W-1:0];
				end
			end
			MODE_READ: begin
				if (live) begin
					o.ok    = 1'b1;
					o.id    = r.slot_id;
					o.key   = slot_key[r.slot_id];
					o.media = slot_media[r.slot_id];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Key mix: some zero, some recurring from the pool, a few near all-ones, rest fresh.
	function automatic logic [KEY_W-1:0] random_key(int pool_pct);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		if (roll < 4 + pool_pct)
			return key_pool[$urandom_range(POOL_N - 1)];
		if (roll < 8 + pool_pct)
			return {KEY_W{1'b1}} ^ KEY_W'($urandom_range(3));
		return $urandom;
	endfunction

	// Mostly in-range ids, with some past the table end up to the field maximum.
	function automatic logic [ID_W-1:0] random_slot();
		if ($urandom_range(99) < 88)
			return ID_W'($urandom_range(SLOTS - 1));
		return ID_W'($urandom_range(255, SLOTS));
	endfunction

	task automatic queue_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
		logic [ID_W-1:0] sid, logic [KEY_W-1:0] media, logic drain_first);
		request_t r;
		r.drain_first = drain_first;
		r.mode        = mode;
		r.chan_key    = key;
		r.slot_id     = sid;
		r.media_key   = media;
		queued_requests.push_back(r);
	endtask

	// Request driver: present a new beat once the previous one is taken.
	// A beat flagged drain_first waits until every outstanding response is back.
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_beat)) begin
			if (queued_requests.size() != 0
				&& !(queued_requests[0].drain_first && due_results.size() != 0)
				&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
				head_req = queued_requests.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.mode      <= head_req.mode;
				req_ch.chan_key  <= head_req.chan_key;
				req_ch.slot_id   <= head_req.slot_id;
				req_ch.media_key <= head_req.media_key;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response sink: stall at random, except through the calm window.
	always @(negedge clk)
		rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Monitor: check response beats first, then log the request beat of this edge,
	// so a response can never be matched against a request taken on the same edge.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time, due_results.size());
			$display("tb: failure");
			$finish;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.ok    = rsp_ch.ok;
				got.id    = rsp_ch.result_id;
				got.key   = rsp_ch.result_key;
				got.media = rsp_ch.result_media;
				if (due_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_CAP)
						$display({"%0t: response beat with nothing expected:",
							" ok %0b id %0d key %h media %h"},
							$time, got.ok, got.id, got.key, got.media);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= REPORT_CAP)
							$display({"%0t: mismatch (expected/actual) ok %0b/%0b id %0d/%0d",
								" key %h/%h media %h/%h"}, $time, want.ok, got.ok,
								want.id, got.id, want.key, got.key, want.media, got.media);
					end
				end
			end
			req_beat = req_ch.valid && req_ch.ready;
			if (req_beat) begin
				taken_req.drain_first = 1'b0;
				taken_req.mode        = req_ch.mode;
				taken_req.chan_key    = req_ch.chan_key;
				taken_req.slot_id     = req_ch.slot_id;
				taken_req.media_key   = req_ch.media_key;
				due_results.push_back(apply_request(taken_req));
				beats_taken++;
			end
			calm = beats_taken >= CALM_FIRST && beats_taken < CALM_LAST;
		end
	end

	initial begin
		int unsigned      generated;
		int unsigned      style;
		int unsigned      span;
		int unsigned      roll;
		logic             drain;
		logic [MODE_W-1:0] mode;

		// Known values on every input from time zero; hold reset.
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = '0;
		req_ch.chan_key  = '0;
		req_ch.slot_id   = '0;
		req_ch.media_key = '0;
		rsp_ch.ready     = 1'b0;
		req_beat         = 1'b0;
		calm             = 1'b0;
		beats_taken      = 0;
		failures         = 0;
		cycle_count      = 0;
		last_alloc       = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_key[i]   = '0;
			slot_media[i] = '0;
		end
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = $urandom | 32'h1;

		// Directed: empty-table behavior, extremes, every mode, every refusal but a full-table map.
		queue_request(MODE_READ,     '0,            '0,           '0,            1'b0);
		queue_request(MODE_FIND,     '0,            '0,           '0,            1'b0);
		queue_request(MODE_MAP,      '0,            '0,           '0,            1'b0);
		queue_request(MODE_MAP,      32'hFFFF_FFFF, 8'd0,         '0,            1'b0);
		queue_request(MODE_MAP,      32'h0000_0001, 8'd0,         '0,            1'b0);
		queue_request(MODE_MAP,      32'hFFFF_FFFF, 8'd0,         '0,            1'b0);
		queue_request(MODE_ATTACH,   '0,            8'd1,         32'hFFFF_FFFF, 1'b0);
		queue_request(MODE_ATTACH,   '0,            8'd0,         32'h1234_5678, 1'b0);
		queue_request(MODE_ATTACH,   '0,            8'hFF,        32'hFFFF_FFFF, 1'b0);
		queue_request(MODE_READ,     '0,            8'd1,         '0,            1'b0);
		queue_request(MODE_READ,     '0,            8'(SLOTS),    '0,            1'b0);
		queue_request(MODE_READ,     '0,            8'(SLOTS - 1), '0,           1'b0);
		queue_request(MODE_FIND,     32'h0000_0001, '0,           '0,            1'b0);
		queue_request(MODE_FIND,     32'h0000_DEAD, '0,           '0,            1'b0);
		queue_request(MODE_FREE_KEY, '0,            '0,           '0,            1'b0);
		queue_request(MODE_FREE_KEY, 32'hFFFF_FFFF, '0,           '0,            1'b0);
		queue_request(MODE_FREE_KEY, 32'hFFFF_FFFF, '0,           '0,            1'b0);
		queue_request(MODE_FREE_ID,  '0,            8'd2,         '0,            1'b0);
		queue_request(MODE_FREE_ID,  '0,            8'd2,         '0,            1'b0);
		queue_request(MODE_FREE_ID,  '0,            8'd200,       '0,            1'b0);
		queue_request(MODE_SPARE_LO, 32'hFFFF_FFFF, 8'hFF,        32'hFFFF_FFFF, 1'b0);
		queue_request(MODE_SPARE_HI, 32'hFFFF_FFFF, 8'hFF,        32'hFFFF_FFFF, 1'b0);
		queue_request(MODE_MAP,      32'h8000_0000, '0,           '0,            1'b0);
		queue_request(MODE_ATTACH,   '0,            8'd3,         '0,            1'b0);
		// Hold the sender here until the pipeline has fully drained.
		queue_request(MODE_READ,     '0,            8'd3,         '0,            1'b1);

		// Random: phases that fill the table, churn it, or drain it.
		generated = 0;
		while (generated < RANDOM_ITEMS) begin
			roll  = $urandom_range(99);
			style = roll < 40 ? STYLE_FILL : (roll < 75 ? STYLE_CHURN : STYLE_DRAIN);
			span  = $urandom_range(120, 20);
			if (span > RANDOM_ITEMS - generated)
				span = RANDOM_ITEMS - generated;
			drain = $urandom_range(3) == 0;
			key_pool[$urandom_range(POOL_N - 1)] = $urandom;
			for (int n = 0; n < span; n++) begin
				roll = $urandom_range(99);
				mode = MODE_W'($urandom_range(int'(MODE_READ)));
				case (style)
					STYLE_FILL:  if (roll < 80) mode = MODE_MAP;
					STYLE_DRAIN: begin
						if (roll < 40)      mode = MODE_FREE_ID;
						else if (roll < 70) mode = MODE_FREE_KEY;
					end
					default:     if (roll < 3) mode = roll[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
				endcase
				queue_request(mode, random_key(style == STYLE_FILL ? 10 : 60), random_slot(),
					$urandom, drain && n == 0);
			end
			generated += span;
		end
		total_items = queued_requests.size();

		// Release reset between edges so the driver sees it cleanly.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to go in and every response to come back, then settle.
		while (beats_taken < total_items || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
